// ----- hdl/pcdp_pkg.sv -----
// Shared constants, types and helpers for the packed code dot product.
// Used by the byte lanes, the merge stage and the top level.
`default_nettype none

package pcdp_pkg;

  localparam int LANES = 8;
  localparam int BYTE_W = 8;
  localparam int WORD_W = LANES * BYTE_W;
  localparam int VCNT_W = 4;
  localparam int EWID_W = 4;
  localparam int PROD_W = 2 * BYTE_W;
  localparam int SUM_W = PROD_W + $clog2(LANES);
  localparam int ACC_W = 32;
  localparam int IN_TDATA_W = ((2 * WORD_W + VCNT_W + 7) / 8) * 8;

  // Internal element mode, decoded from the element_width register.
  localparam logic [1:0] MODE_W8 = 2'd0;
  localparam logic [1:0] MODE_W4 = 2'd1;
  localparam logic [1:0] MODE_W1 = 2'd2;
  localparam logic [1:0] MODE_W2 = 2'd3;

  typedef logic [LANES-1:0][PROD_W-1:0] prod_vec_t;

  typedef struct packed {
    logic       load;
    logic [1:0] mode;
  } lane_ctrl_t;

  function automatic logic [1:0] decode_width(input logic [EWID_W-1:0] w);
    logic [1:0] m;
    case (w)
      4'd8:    m = MODE_W8;
      4'd4:    m = MODE_W4;
      4'd1:    m = MODE_W1;
      default: m = MODE_W2;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pcdp_lane.sv -----
// One byte lane: product of two code bytes for the configured element width.
// Depends on pcdp_pkg; the result is held in a lane register.
`default_nettype none

module pcdp_lane
  import pcdp_pkg::*;
(
  input  wire logic              clk,
  input  wire lane_ctrl_t        ctrl,
  input  wire logic [BYTE_W-1:0] x,
  input  wire logic [BYTE_W-1:0] y,
  output logic      [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] w8_prod;
  logic [PROD_W-1:0] w4_prod;
  logic [PROD_W-1:0] w1_prod;
  logic [PROD_W-1:0] w2_prod;

  assign w8_prod = x * y;
  assign w4_prod = PROD_W'(x[3:0] * y[3:0]) + PROD_W'(x[7:4] * y[7:4]);
  assign w1_prod = PROD_W'($countones(x & y));

  // Four 2-bit elements per byte.
  always_comb begin
    w2_prod = '0;
    for (int k = 0; k < BYTE_W / 2; k++) begin
      w2_prod = w2_prod + PROD_W'(x[2*k +: 2] * y[2*k +: 2]);
    end
  end

  always_comb begin
    case (ctrl.mode)
      MODE_W8: prod_nxt = w8_prod;
      MODE_W4: prod_nxt = w4_prod;
      MODE_W1: prod_nxt = w1_prod;
      default: prod_nxt = w2_prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- hdl/pcdp_merge.sv -----
// Merge stage: adds the lane products of one word into a registered sum.
// Depends on pcdp_pkg.
`default_nettype none

module pcdp_merge
  import pcdp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire prod_vec_t        prods,
  output logic      [SUM_W-1:0] sum
);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_nxt = sum_nxt + SUM_W'(prods[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

// ----- hdl/packed_code_dot_product.sv -----
// Top level of the packed code dot product: input stage, byte lanes,
// merge stage and accumulator. Depends on pcdp_pkg, pcdp_lane, pcdp_merge.
//
//  channel | direction | handshake                    | contents
//  in_     | slave     | in_tvalid / in_tready        | two code words, valid count, tlast
//  out_    | master    | out_tvalid / out_tready      | 32-bit dot product
//  cfg_    | slave     | cfg_valid / cfg_ready        | element width
//
// One word is accepted per cycle unless in_tready is low. The last word of a vector
// passes the input register, the lane multiplier stage and the merge adder stage;
// the accumulator add then writes its sum into the output register on the push.
// Reset clears all stage valids, the running sum and sets the width to 8.
// A stalled output holds only words that end a vector; other words keep flowing
// into the running sum until the next last word reaches the merge stage, after
// which three words wait in the pipeline and in_tready drops.
`default_nettype none

module packed_code_dot_product
  import pcdp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // first_word [63:0], second_word [127:64], valid_bytes [131:128], zeros above
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // dot_product [31:0]
  output logic      [ACC_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [EWID_W-1:0]     cfg_data
);

  logic [1:0]        mode_r;
  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  logic              s1_last_r, s2_last_r, s3_last_r;
  logic [WORD_W-1:0] s1_a_r, s1_b_r;
  logic [WORD_W-1:0] keep;
  logic [VCNT_W-1:0] vcnt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              out_vld_r;
  logic [ACC_W-1:0]  out_data_r;
  logic              in_acc, s3_go, s3_free, s2_free, s1_free;
  logic              s2_load, s3_load, push, pop;
  lane_ctrl_t        lane_ctrl;
  prod_vec_t         prods;
  logic [SUM_W-1:0]  merge_sum;

  assign cfg_ready = 1'b1;

  assign vcnt = in_tdata[2*WORD_W +: VCNT_W];

  // A byte counts when its index is below the valid count (counts above 8 saturate).
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      keep[i*BYTE_W +: BYTE_W] = {BYTE_W{(VCNT_W'(i) < vcnt)}};
    end
  end

  assign s3_go   = s3_vld_r && (!s3_last_r || !out_vld_r || out_tready);
  assign s3_free = !s3_vld_r || s3_go;
  assign s2_free = !s2_vld_r || s3_free;
  assign s1_free = !s1_vld_r || s2_free;
  assign s2_load = s1_vld_r && s2_free;
  assign s3_load = s2_vld_r && s3_free;
  assign in_tready = s1_free;
  assign in_acc  = in_tvalid && s1_free;
  assign push    = s3_go && s3_last_r;
  assign pop     = out_vld_r && out_tready;

  assign acc_nxt = acc_r + ACC_W'(merge_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_W8;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      acc_r     <= '0;
    end else begin
      if (cfg_valid) begin
        mode_r <= decode_width(cfg_data);
      end
      s1_vld_r  <= in_acc || (s1_vld_r && !s2_free);
      s2_vld_r  <= s2_load || (s2_vld_r && !s3_free);
      s3_vld_r  <= s3_load || (s3_vld_r && !s3_go);
      out_vld_r <= push || (out_vld_r && !pop);
      if (s3_go) begin
        acc_r <= s3_last_r ? '0 : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_a_r    <= in_tdata[0 +: WORD_W] & keep;
      s1_b_r    <= in_tdata[WORD_W +: WORD_W] & keep;
      s1_last_r <= in_tlast;
    end
    if (s2_load) begin
      s2_last_r <= s1_last_r;
    end
    if (s3_load) begin
      s3_last_r <= s2_last_r;
    end
    if (push) begin
      out_data_r <= acc_nxt;
    end
  end

  assign lane_ctrl.load = s2_load;
  assign lane_ctrl.mode = mode_r;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pcdp_lane u_lane (
      .clk  (clk),
      .ctrl (lane_ctrl),
      .x    (s1_a_r[g*BYTE_W +: BYTE_W]),
      .y    (s1_b_r[g*BYTE_W +: BYTE_W]),
      .prod (prods[g])
    );
  end

  pcdp_merge u_merge (
    .clk   (clk),
    .load  (s3_load),
    .prods (prods),
    .sum   (merge_sum)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- hdl/pcdp_checker.sv -----
// Port-level checks for packed_code_dot_product, bound to the top level.
// Depends on pcdp_pkg for the port widths.
`default_nettype none

module pcdp_checker
  import pcdp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [ACC_W-1:0]      out_tdata,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // Input back-pressure only ever comes from a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a held result");

  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind packed_code_dot_product pcdp_checker u_pcdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire

// ----- bench/packed_code_dot_product_tb.sv -----
// Self-checking bench for packed_code_dot_product: directed and random code words at every
// element width, with a predictor of the running sum compared to each emitted dot product.
// Depends on pcdp_pkg and the packed_code_dot_product RTL.
`default_nettype none

module packed_code_dot_product_tb;
  import pcdp_pkg::*;

  localparam logic [EWID_W-1:0] WIDTH_BYTE   = 4'd8;
  localparam logic [EWID_W-1:0] WIDTH_NIBBLE = 4'd4;
  localparam logic [EWID_W-1:0] WIDTH_BIT    = 4'd1;
  localparam logic [EWID_W-1:0] WIDTH_PAIR   = 4'd2;
  localparam logic [EWID_W-1:0] WIDTH_ZERO   = 4'd0;
  localparam logic [EWID_W-1:0] WIDTH_TOP    = 4'd15;
  localparam logic [WORD_W-1:0] PAIR_LOW_PLANE = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 500000;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [ACC_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [EWID_W-1:0]     cfg_data = '0;

  logic [EWID_W-1:0] model_width;
  logic [ACC_W-1:0]  model_sum;
  logic [ACC_W-1:0]  pending_sums[$];
  logic [15:0]       widths_seen;
  int error_count = 0;
  int words_sent = 0;
  int sums_checked = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  packed_code_dot_product dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Sum of element products of one word pair, masked to its valid bytes.
  function automatic logic [ACC_W-1:0] word_products(input logic [WORD_W-1:0] a,
                                                     input logic [WORD_W-1:0] b,
                                                     input logic [VCNT_W-1:0] vb,
                                                     input logic [EWID_W-1:0] width);
    logic [WORD_W-1:0] keep, x, y, xl, xh, yl, yh;
    logic [ACC_W-1:0]  total;
    int n, i;
    n = (vb > LANES) ? LANES : int'(vb);
    keep = (n >= LANES) ? ALL_ONES : ((64'd1 << (8 * n)) - 64'd1);
    x = a & keep;
    y = b & keep;
    total = '0;
    case (width)
      WIDTH_BYTE: begin
        for (i = 0; i < LANES; i++)
          total += ACC_W'(x[8*i +: 8]) * ACC_W'(y[8*i +: 8]);
      end
      WIDTH_NIBBLE: begin
        for (i = 0; i < LANES; i++)
          total += ACC_W'(x[8*i +: 4]) * ACC_W'(y[8*i +: 4])
                 + ACC_W'(x[8*i+4 +: 4]) * ACC_W'(y[8*i+4 +: 4]);
      end
      WIDTH_BIT: total = ACC_W'($countones(x & y));
      default: begin
        // Any unlisted width works on 2-bit fields through weighted bit planes.
        xl = x & PAIR_LOW_PLANE;
        xh = (x >> 1) & PAIR_LOW_PLANE;
        yl = y & PAIR_LOW_PLANE;
        yh = (y >> 1) & PAIR_LOW_PLANE;
        total = ACC_W'($countones(xl & yl)) + ACC_W'(2 * $countones(xl & yh))
              + ACC_W'(2 * $countones(xh & yl)) + ACC_W'(4 * $countones(xh & yh));
      end
    endcase
    return total;
  endfunction

  function automatic logic [WORD_W-1:0] random_code_word();
    logic [WORD_W-1:0] w;
    int i;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: w = ALL_ONES;
      1: w = '0;
      2: begin
        for (i = 0; i < LANES; i++)
          if ($urandom_range(0, 1) == 1) w[8*i +: 8] = {8{w[8*i]}};
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                           input logic [VCNT_W-1:0] vb, input logic last);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 2 * WORD_W - VCNT_W){1'b0}}, vb, b, a};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    model_sum += word_products(a, b, vb, model_width);
    if (last) begin
      pending_sums.push_back(model_sum);
      model_sum = '0;
    end
  endtask

  // Stops the input and waits until every expected sum is out and the pipeline is empty.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic [EWID_W-1:0] w);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_width = w;
    widths_seen[w] = 1'b1;
  endtask

  task automatic send_random_vector(input int len);
    int i;
    logic [VCNT_W-1:0] vb;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0 || (i == len - 1 && $urandom_range(0, 1) == 1))
        vb = VCNT_W'($urandom_range(0, 15));
      else
        vb = VCNT_W'(LANES);
      send_word(random_code_word(), random_code_word(), vb, i == len - 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        $error("dot_product: no sum expected, actual %0d", out_tdata);
        error_count++;
      end else begin
        if (out_tdata !== pending_sums[0]) begin
          $error("dot_product mismatch: expected %0d, actual %0d", pending_sums[0], out_tdata);
          error_count++;
        end
        void'(pending_sums.pop_front());
        sums_checked++;
      end
    end
  end

  // The width register is left at its reset value of 8 here.
  task automatic test_default_width();
    send_word(ALL_ONES, ALL_ONES, 4'd8, 1'b1);
    send_word(ALL_ONES, ALL_ONES, 4'd0, 1'b1);
    send_word(ALL_ONES, ALL_ONES, 4'd15, 1'b1);
    send_word(64'h0123_4567_89ab_cdef, ALL_ONES, 4'd9, 1'b1);
    send_word(ALL_ONES, 64'h0000_0000_0000_00ff, 4'd1, 1'b1);
    send_word(64'h8040_2010_0804_0201, 64'hfedc_ba98_7654_3210, 4'd8, 1'b0);
    send_word('0, ALL_ONES, 4'd8, 1'b0);
    send_word(ALL_ONES, ALL_ONES, 4'd3, 1'b1);
  endtask

  task automatic test_each_width();
    logic [EWID_W-1:0] widths[6];
    int i;
    widths = '{WIDTH_NIBBLE, WIDTH_BIT, WIDTH_PAIR, WIDTH_ZERO, WIDTH_TOP, WIDTH_BYTE};
    for (i = 0; i < 6; i++) begin
      set_width(widths[i]);
      send_word(ALL_ONES, ALL_ONES, 4'd8, 1'b1);
      send_word(64'h5a5a_c3c3_0ff0_9669, 64'ha5a5_3c3c_f00f_6996, 4'd7, 1'b1);
    end
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct);
    int seg, count, len;
    logic [EWID_W-1:0] w;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (seg = 0; seg < 4; seg++) begin
      case ($urandom_range(0, 4))
        0: w = WIDTH_BYTE;
        1: w = WIDTH_NIBBLE;
        2: w = WIDTH_BIT;
        3: w = WIDTH_PAIR;
        default: w = EWID_W'($urandom_range(0, 15));
      endcase
      set_width(w);
      count = 0;
      while (count < 60) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
        send_random_vector(len);
        count += len;
      end
    end
  endtask

  initial begin
    model_width = WIDTH_BYTE;
    model_sum   = '0;
    widths_seen = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_width();
    test_each_width();
    test_random_phase(15, 50);
    test_random_phase(50, 15);
    test_random_phase(0, 0);
    drain_block();

    $display("Sent %0d words and checked %0d sums, element widths written: %b.",
             words_sent, sums_checked, widths_seen);
    $display("Covered valid counts 0 to 15 and idle and stall on both sides.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/pcdp_pkg.sv
hdl/pcdp_lane.sv
hdl/pcdp_merge.sv
hdl/packed_code_dot_product.sv
hdl/pcdp_checker.sv
bench/packed_code_dot_product_tb.sv
